### hw/rtl/moesi_l2_line_coherence_controller_unit_defines.svh
// Assertion macros used by the coherence controller checker.
`ifndef MOESI_L2_LINE_COHERENCE_CONTROLLER_UNIT_DEFINES_SVH
`define MOESI_L2_LINE_COHERENCE_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define MLCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define MLCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mlcc_pkg.sv
// Types, codes and sizes of the MOESI L2 line coherence controller.
package mlcc_pkg;

  localparam int unsigned LineIdxW = 8;
  localparam int unsigned NumLines = 2 ** LineIdxW;
  localparam int unsigned StateW   = 3;

  typedef enum logic [2:0] {
    StI  = 3'd0,
    StIS = 3'd1,
    StIE = 3'd2,
    StS  = 3'd3,
    StE  = 3'd4,
    StM  = 3'd5,
    StO  = 3'd6,
    StOE = 3'd7
  } line_state_e;

  typedef enum logic [1:0] {
    KindL1Req   = 2'd0,
    KindAceResp = 2'd1,
    KindSnoop   = 2'd2,
    KindMarkMod = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    L1GetShared = 2'd0,
    L1GetExcl   = 2'd1,
    L1Op2       = 2'd2,
    L1Op3       = 2'd3
  } l1_op_e;

  typedef enum logic [1:0] {
    SnpReadShared   = 2'd0,
    SnpReadUnique   = 2'd1,
    SnpMakeInvalid  = 2'd2,
    SnpCleanInvalid = 2'd3
  } snoop_op_e;

  typedef enum logic [1:0] {
    AceReadShared  = 2'd0,
    AceReadUnique  = 2'd1,
    AceCleanUnique = 2'd2,
    AceNone        = 2'd3
  } ace_op_e;

  typedef enum logic [1:0] {
    LinesNone       = 2'd0,
    LinesSetShared  = 2'd1,
    LinesInvalidate = 2'd2,
    LinesRsvd       = 2'd3
  } lines_action_e;

  typedef enum logic [1:0] {
    TxnNone  = 2'd0,
    TxnStart = 2'd1,
    TxnEnd   = 2'd2,
    TxnRsvd  = 2'd3
  } txn_action_e;

  localparam logic [3:0] FlagDataTransfer = 4'b0001;
  localparam logic [3:0] FlagPassDirty    = 4'b0010;
  localparam logic [3:0] FlagIsShared     = 4'b0100;
  localparam logic [3:0] FlagWasUnique    = 4'b1000;

  typedef struct packed {
    logic [1:0]          kind;
    logic [LineIdxW-1:0] line_index;
    logic [1:0]          op;
    logic                resp_shared;
    logic                resp_dirty;
    logic                snoop_evicted;
  } item_t;

  typedef struct packed {
    logic              ace_cmd_valid;
    logic [1:0]        ace_cmd_op;
    logic              l1_rsp_valid;
    logic              l1_rsp_shared;
    logic              snoop_rsp_valid;
    logic [3:0]        snoop_rsp_flags;
    logic [1:0]        l1_lines_action;
    logic [1:0]        txn_action;
    logic              remove_line;
    logic              consumed;
    logic              error;
    logic [StateW-1:0] new_state;
  } result_t;

endpackage

### hw/rtl/mlcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mlcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/moesi_l2_line_coherence_controller_unit.sv
// MOESI L2 line coherence controller: state store, decode and result register.
// The state RAM read and the item register load on acceptance; the decode then loads the
// result register when the item advances. Throughput is one transaction per cycle unless
// the result side stalls; a line updated by the previous transaction is forwarded around
// the RAM. Reset marks every line invalid at once through per-line valid bits, so
// transactions are taken in the first cycle after reset.
module moesi_l2_line_coherence_controller_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mlcc_pkg::item_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mlcc_pkg::result_t out_data_o
);
  import mlcc_pkg::*;

  logic                in_acc;
  logic                s1_adv;
  logic                s1_vld_q;
  item_t               s1_item_q;
  logic [NumLines-1:0] vld_q;
  logic [NumLines-1:0] vld_d;
  logic                vbit_q;
  logic                byp_hit_q;
  logic                byp_hit_d;
  logic [StateW-1:0]   byp_state_q;
  logic [StateW-1:0]   ram_rdata;
  logic [StateW-1:0]   cur_state;
  logic                out_vld_q;
  result_t             out_q;
  result_t             res_d;
  logic [LineIdxW-1:0] in_idx;
  logic [LineIdxW-1:0] s1_idx;

  assign in_idx     = in_data_i.line_index[LineIdxW-1:0];
  assign s1_idx     = s1_item_q.line_index[LineIdxW-1:0];
  assign s1_adv     = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  mlcc_ram #(
    .Width(StateW),
    .Depth(NumLines)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_idx),
    .wdata_i (res_d.new_state),
    .re_i    (in_acc),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    vld_d = vld_q;
    if (s1_adv) begin
      vld_d[s1_idx] = 1'b1;
    end
  end

  assign byp_hit_d = s1_adv && (s1_idx == in_idx);

  always_comb begin
    if (byp_hit_q) begin
      cur_state = byp_state_q;
    end else if (vbit_q) begin
      cur_state = ram_rdata;
    end else begin
      cur_state = StI;
    end
  end

  always_comb begin
    line_state_e st;
    line_state_e seen;
    st    = line_state_e'(cur_state);
    seen  = s1_item_q.snoop_evicted ? StI : st;
    res_d = '0;
    res_d.new_state = cur_state;
    unique case (kind_e'(s1_item_q.kind))
      KindL1Req: begin
        if (s1_item_q.op == L1GetShared || s1_item_q.op == L1GetExcl) begin
          case (st)
            StI: begin
              res_d.ace_cmd_valid = 1'b1;
              res_d.ace_cmd_op    = (s1_item_q.op == L1GetExcl) ? AceReadUnique
                                                                : AceReadShared;
              res_d.txn_action    = TxnStart;
              res_d.consumed      = 1'b1;
              res_d.new_state     = (s1_item_q.op == L1GetExcl) ? StIE : StIS;
            end
            StS: begin
              if (s1_item_q.op == L1GetShared) begin
                res_d.l1_rsp_valid  = 1'b1;
                res_d.l1_rsp_shared = 1'b1;
                res_d.consumed      = 1'b1;
              end
            end
            StO: begin
              if (s1_item_q.op == L1GetExcl) begin
                res_d.ace_cmd_valid = 1'b1;
                res_d.ace_cmd_op    = AceCleanUnique;
                res_d.txn_action    = TxnStart;
                res_d.consumed      = 1'b1;
                res_d.new_state     = StOE;
              end
            end
            StE: begin
              res_d.l1_rsp_valid = 1'b1;
              res_d.consumed     = 1'b1;
              if (s1_item_q.op == L1GetShared) begin
                res_d.l1_rsp_shared   = 1'b1;
                res_d.l1_lines_action = LinesSetShared;
                res_d.new_state       = StS;
              end else begin
                res_d.l1_lines_action = LinesInvalidate;
              end
            end
            default: begin
            end
          endcase
        end
      end
      KindAceResp: begin
        if (st == StIS || st == StIE || st == StOE) begin
          res_d.l1_rsp_valid = 1'b1;
          res_d.txn_action   = TxnEnd;
          res_d.consumed     = 1'b1;
        end
        case (st)
          StIS: begin
            if (s1_item_q.resp_shared && s1_item_q.resp_dirty) begin
              res_d.new_state = StO;
            end else if (!s1_item_q.resp_shared && !s1_item_q.resp_dirty) begin
              res_d.new_state = StE;
            end else begin
              res_d.new_state     = StS;
              res_d.l1_rsp_shared = 1'b1;
            end
          end
          StIE: begin
            res_d.new_state = s1_item_q.resp_dirty ? StO : StE;
          end
          StOE: begin
            res_d.new_state = StE;
          end
          default: begin
          end
        endcase
      end
      KindSnoop: begin
        if (s1_item_q.op == SnpReadShared) begin
          if (seen == StI || seen == StS || seen == StE || seen == StM) begin
            res_d.snoop_rsp_valid = 1'b1;
            res_d.consumed        = 1'b1;
          end
          if (seen == StE) begin
            res_d.snoop_rsp_flags = FlagDataTransfer | FlagIsShared | FlagWasUnique;
            res_d.new_state       = StS;
          end else if (seen == StM) begin
            res_d.snoop_rsp_flags = FlagDataTransfer | FlagIsShared | FlagWasUnique;
            res_d.new_state       = StO;
            res_d.l1_lines_action = LinesSetShared;
          end
        end else if (st == StI || st == StS || st == StE || st == StM || st == StO) begin
          res_d.snoop_rsp_valid = 1'b1;
          res_d.l1_lines_action = LinesInvalidate;
          res_d.remove_line     = 1'b1;
          res_d.consumed        = 1'b1;
          res_d.new_state       = StI;
          if (s1_item_q.op == SnpReadUnique) begin
            res_d.snoop_rsp_flags = (st == StM || st == StO)
                                  ? (FlagDataTransfer | FlagPassDirty | FlagWasUnique)
                                  : (FlagDataTransfer | FlagWasUnique);
          end else if (s1_item_q.op == SnpCleanInvalid && (st == StM || st == StO)) begin
            res_d.snoop_rsp_flags = FlagDataTransfer | FlagPassDirty;
          end
        end
      end
      KindMarkMod: begin
        res_d.consumed = 1'b1;
        if (st == StM || st == StO || st == StE) begin
          res_d.new_state = StM;
        end else begin
          res_d.error = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      byp_hit_q <= 1'b0;
      vld_q     <= '0;
    end else begin
      vld_q <= vld_d;
      if (in_acc) begin
        byp_hit_q <= byp_hit_d;
      end
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q   <= in_data_i;
      vbit_q      <= vld_q[in_idx];
      byp_state_q <= res_d.new_state;
    end
    if (s1_adv) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/mlcc_checker.sv
// Port-level checker for the coherence controller and its bind statement.
`include "moesi_l2_line_coherence_controller_unit_defines.svh"

module mlcc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input mlcc_pkg::item_t   in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input mlcc_pkg::result_t out_data_o
);
  import mlcc_pkg::*;

  `MLCC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result transaction changed while stalled")
  `MLCC_ASSERT_IMP(a_ready_only_when_full, !in_ready_o, out_valid_o && !out_ready_i, "input stalled while the result side was free")
  `MLCC_ASSERT_IMP(a_unconsumed_quiet, out_valid_o && !out_data_o.consumed, !out_data_o.ace_cmd_valid && !out_data_o.l1_rsp_valid && !out_data_o.snoop_rsp_valid && !out_data_o.remove_line && !out_data_o.error, "unconsumed transaction raised an action")
  `MLCC_ASSERT_IMP(a_remove_invalid, out_valid_o && out_data_o.remove_line, out_data_o.snoop_rsp_valid && out_data_o.new_state == StI, "line removed without an invalidating snoop")
  `MLCC_ASSERT_IMP(a_error_alone, out_valid_o && out_data_o.error, out_data_o.consumed && !out_data_o.ace_cmd_valid && !out_data_o.l1_rsp_valid && !out_data_o.snoop_rsp_valid, "error transaction raised an action")

endmodule

bind moesi_l2_line_coherence_controller_unit mlcc_checker u_mlcc_checker (.*);
